// File: sv/ic2d_pkg.sv
// Shared types, constants and helper functions for the 2-D image convolution block.
// No dependencies; the front end, queue, back end, top level and testbench import this package.
`default_nettype none
package ic2d_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_MASK   = 5;
  localparam int COEF_BITS  = 12;
  localparam int KROWS      = 5;
  localparam int LINES      = MAX_MASK - 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int KROW_W     = 60;
  localparam int WIN_N      = MAX_MASK * MAX_MASK;
  localparam int ACC_W      = 25;
  localparam int DVD_W      = ACC_W - 1;
  localparam int DIV_W      = 12;
  localparam int CNT_W      = 5;

  // Register indexes
  localparam logic [2:0] REG_DIVISOR    = 3'd5;
  localparam logic [2:0] REG_LINE_WIDTH = 3'd6;
  localparam logic [2:0] REG_MASK_SHAPE = 3'd7;

  typedef logic [WIN_N-1:0][7:0] win_t;

  // Effective configuration seen by the datapath
  typedef struct packed {
    logic [KROWS-1:0][KROW_W-1:0] kern;
    logic [DIV_W-1:0]             div;
    logic [COL_W:0]               width;
    logic [2:0]                   mw;
    logic [2:0]                   mh;
  } cfg_t;

  // One queued window job
  typedef struct packed {
    win_t             win;
    logic [COL_W-1:0] ocol;
    logic [ROW_W-1:0] orow;
    logic             last;
  } job_t;

  typedef enum logic [0:0] {F_IDLE, F_UPD} front_st_e;
  typedef enum logic [2:0] {B_IDLE, B_MAC, B_PREP, B_DIV, B_OUT} back_st_e;

  // Clamp a mask dimension to 1..MAX_MASK
  function automatic logic [2:0] clamp_dim(input logic [2:0] v);
    logic [2:0] r;
    r = v;
    if (v == 3'd0) r = 3'd1;
    else if (v > 3'(MAX_MASK)) r = 3'(MAX_MASK);
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/ic2d_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module ic2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: sv/ic2d_front.sv
// Front end: accepts pixels, keeps counters, line store and window, queues jobs.
// Depends on ic2d_pkg and ic2d_ram.
`default_nettype none
module ic2d_front import ic2d_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] pixel_i,
  input  wire logic       frame_start_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output job_t            job_o
);

  front_st_e        st_q, st_d;
  logic             clr_q;
  logic [COL_W-1:0] clr_addr_q;
  logic [COL_W-1:0] col_q, col_d, cc_q, acc_cc;
  logic [ROW_W-1:0] row_q, row_d, rc_q, acc_rc;
  logic [7:0]       px_q;
  win_t             win_q, win_d;
  logic             ram_we;
  logic [COL_W-1:0] ram_waddr;
  logic [8*LINES-1:0] ram_wdata, ram_rdata;
  logic             accept, hit, last;

  ic2d_ram #(.WIDTH(8*LINES), .DEPTH(MAX_WIDTH)) u_lines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (acc_cc),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (st_q == F_IDLE) && !clr_q && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign acc_cc     = frame_start_i ? '0 : col_q;
  assign acc_rc     = frame_start_i ? '0 : row_q;

  // Classify the pixel, shift the window and write back the line column
  always_comb begin
    st_d  = st_q;
    col_d = col_q;
    row_d = row_q;
    win_d = win_q;
    for (int r = 0; r < MAX_MASK; r++) begin
      for (int c = 0; c < MAX_MASK - 1; c++) win_d[r*MAX_MASK+c] = win_q[r*MAX_MASK+c+1];
      win_d[r*MAX_MASK+MAX_MASK-1] = (r < LINES) ? ram_rdata[(r%LINES)*8 +: 8] : px_q;
    end
    hit  = ({1'b0, cc_q} + 1'b1 >= {{(COL_W-2){1'b0}}, cfg_i.mw})
        && ({1'b0, rc_q} + 1'b1 >= {{(ROW_W-2){1'b0}}, cfg_i.mh});
    last = ({1'b0, cc_q} + 1'b1 >= cfg_i.width);
    push_o    = 1'b0;
    ram_we    = clr_q;
    ram_waddr = clr_q ? clr_addr_q : cc_q;
    ram_wdata = clr_q ? '0 : {px_q, ram_rdata[8*LINES-1:8]};
    job_o.win  = win_d;
    job_o.ocol = cc_q - COL_W'(cfg_i.mw - 3'd1);
    job_o.orow = rc_q - ROW_W'(cfg_i.mh - 3'd1);
    job_o.last = last;
    unique case (st_q)
      F_IDLE: begin
        if (accept) st_d = F_UPD;
      end
      F_UPD: begin
        ram_we = 1'b1;
        push_o = hit;
        st_d   = F_IDLE;
        if (last) begin
          col_d = '0;
          row_d = (rc_q < ROW_W'(MAX_HEIGHT - 1)) ? rc_q + 1'b1 : rc_q;
        end else begin
          col_d = cc_q + 1'b1;
          row_d = rc_q;
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  // Control state and window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= F_IDLE;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
      win_q      <= '0;
    end else begin
      st_q <= st_d;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == COL_W'(MAX_WIDTH - 1)) clr_q <= 1'b0;
      end
      if (st_q == F_UPD) begin
        col_q <= col_d;
        row_q <= row_d;
        win_q <= win_d;
      end
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cc_q <= acc_cc;
      rc_q <= acc_rc;
      px_q <= pixel_i;
    end
  end

endmodule
`default_nettype wire

// File: sv/ic2d_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on ic2d_pkg.
`default_nettype none
module ic2d_queue import ic2d_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  input  wire logic pop_i,
  output job_t      head_o,
  output logic      full_o,
  output logic      empty_o
);

  job_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign head_o  = ent_q[rp_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= job_i;
  end

endmodule
`default_nettype wire

// File: sv/ic2d_back.sv
// Back end: multiply-accumulate over the mask, serial divide, saturate, output register.
// Depends on ic2d_pkg.
`default_nettype none
module ic2d_back import ic2d_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cfg_t         cfg_i,
  input  wire job_t         head_i,
  input  wire logic         empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [7:0]        value_o,
  output logic [COL_W-1:0]  out_column_o,
  output logic [ROW_W-1:0]  out_row_o,
  output logic              row_end_o
);

  back_st_e                st_q, st_d;
  job_t                    job_q;
  logic [2:0]              my_q, mx_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [DVD_W-1:0]        dvd_q;
  logic [DIV_W:0]          rem_q, rem_sh;
  logic [CNT_W-1:0]        cnt_q;
  logic [2:0]              wr, wc;
  logic [4:0]              widx;
  logic [COEF_BITS-1:0]    coef;
  logic signed [COEF_BITS+8:0] prod;
  logic                    load_out;
  logic                    qbit;

  // Select coefficient and pixel for the current mask position
  always_comb begin
    wr   = my_q + (3'(MAX_MASK) - cfg_i.mh);
    wc   = mx_q + (3'(MAX_MASK) - cfg_i.mw);
    widx = 5'(wr) * 5'(MAX_MASK) + 5'(wc);
    coef = cfg_i.kern[my_q][mx_q*COEF_BITS +: COEF_BITS];
    prod = $signed(coef) * $signed({1'b0, job_q.win[widx]});
    rem_sh = {rem_q[DIV_W-1:0], dvd_q[DVD_W-1]};
    qbit   = (rem_sh >= {1'b0, cfg_i.div});
  end

  assign load_out = (st_q == B_OUT) && (!out_valid_o || out_ready_i);
  assign pop_o    = (st_q == B_IDLE) && !empty_i;

  // Sequence the job
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      B_IDLE: if (!empty_i) st_d = B_MAC;
      B_MAC:  if (mx_q == cfg_i.mw - 3'd1 && my_q == cfg_i.mh - 3'd1) st_d = B_PREP;
      B_PREP: st_d = B_DIV;
      B_DIV:  if (cnt_q == CNT_W'(DVD_W - 1)) st_d = B_OUT;
      B_OUT:  if (load_out) st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load_out) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      B_IDLE: begin
        job_q <= head_i;
        acc_q <= '0;
        my_q  <= '0;
        mx_q  <= '0;
      end
      B_MAC: begin
        acc_q <= acc_q + ACC_W'(prod);
        if (mx_q == cfg_i.mw - 3'd1) begin
          mx_q <= '0;
          my_q <= my_q + 3'd1;
        end else begin
          mx_q <= mx_q + 3'd1;
        end
      end
      B_PREP: begin
        // negative sums clip to zero: divide zero instead
        dvd_q <= acc_q[ACC_W-1] ? '0 : acc_q[DVD_W-1:0];
        rem_q <= '0;
        cnt_q <= '0;
      end
      B_DIV: begin
        rem_q <= qbit ? rem_sh - {1'b0, cfg_i.div} : rem_sh;
        dvd_q <= {dvd_q[DVD_W-2:0], qbit};
        cnt_q <= cnt_q + 1'b1;
      end
      B_OUT: begin
        if (load_out) begin
          value_o      <= (dvd_q > DVD_W'(255)) ? 8'd255 : dvd_q[7:0];
          out_column_o <= job_q.ocol;
          out_row_o    <= job_q.orow;
          row_end_o    <= job_q.last;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/image_convolution_2d.sv
// Top level of the 2-D image convolution: configuration registers and the
// front end, job queue and back end. Depends on ic2d_pkg and all ic2d_ modules.
//
//  port group      dir  payload
//  s_axis_*        in   tdata[7:0] pixel, tuser frame_start
//  m_axis_*        out  tdata value/out_column/out_row, tlast row_end
//  cfg_*           in   cfg_index_i register index, cfg_data_i value
//
// The front end takes a pixel only while idle and the queue is not full, then reads
// and writes back the line store. The back end works on one result at a time (one
// MAC per mask tap, a bit per cycle divider), which sets the rate when results are
// produced. After reset a pass clears all 2048 line store addresses; no pixel is
// taken then. A two-entry queue lets the front run on while the output stalls.
`default_nettype none
module image_convolution_2d import ic2d_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] pixel
  input  wire logic        s_axis_tuser_i,   // frame_start
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [7:0] value, [18:8] out_column, [30:19] out_row
  output logic             m_axis_tlast_o,   // row_end
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [KROW_W-1:0] cfg_data_i
);

  logic [KROWS-1:0][KROW_W-1:0] kern_q;
  logic [DIV_W-1:0] div_q;
  logic [11:0]      lw_q;
  logic [11:0]      shape_q;
  cfg_t             cfg;
  logic             push, pop, full, empty;
  job_t             job, head;
  logic [7:0]       value;
  logic [COL_W-1:0] ocol;
  logic [ROW_W-1:0] orow;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q  <= '0;
      div_q   <= 12'd1;
      lw_q    <= 12'd2048;
      shape_q <= 12'd603;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DIVISOR:    div_q   <= cfg_data_i[DIV_W-1:0];
        REG_LINE_WIDTH: lw_q    <= cfg_data_i[11:0];
        REG_MASK_SHAPE: shape_q <= cfg_data_i[11:0];
        default:        kern_q[cfg_index_i] <= cfg_data_i;
      endcase
    end
  end

  // Derive effective settings
  always_comb begin
    cfg.kern  = kern_q;
    cfg.div   = (div_q == '0) ? DIV_W'(1) : div_q;
    cfg.width = (lw_q == '0) ? (COL_W+1)'(1)
              : (lw_q > 12'(MAX_WIDTH)) ? (COL_W+1)'(MAX_WIDTH) : (COL_W+1)'(lw_q);
    cfg.mw    = clamp_dim(shape_q[2:0]);
    cfg.mh    = clamp_dim(shape_q[5:3]);
  end

  ic2d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .pixel_i       (s_axis_tdata_i),
    .frame_start_i (s_axis_tuser_i),
    .q_full_i      (full),
    .push_o        (push),
    .job_o         (job)
  );

  ic2d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  ic2d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .value_o      (value),
    .out_column_o (ocol),
    .out_row_o    (orow),
    .row_end_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, orow, ocol, value};

endmodule
`default_nettype wire

// File: sim/tb_image_convolution_2d.sv
// Testbench for image_convolution_2d: streams pixel frames and checks each windowed
// convolution result against a built-in predictor. Depends on ic2d_pkg and the RTL.
`default_nettype none
module tb_image_convolution_2d import ic2d_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_KROW0 = 3'd0;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [7:0]       value;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             row_end;
  } conv_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic m_axis_tlast_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [KROW_W-1:0] cfg_data_i = '0;

  image_convolution_2d dut (.*);

  // Predictor state and shadow registers
  logic [KROW_W-1:0] kern_q [KROWS];
  logic [11:0] div_q, width_q, shape_q;
  logic [7:0] line_mem [LINES][MAX_WIDTH];
  logic [7:0] win_q [MAX_MASK][MAX_MASK];
  int unsigned col_cnt, row_cnt;

  conv_result_t pending_q[$];
  int unsigned cycles = 0;
  int errors = 0;
  int src_idle_pct = 0;
  int rcv_stall_pct = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[image_convolution_2d] ERROR");
      $finish;
    end
  end

  function automatic int unsigned clip_dim(input int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_MASK) return MAX_MASK;
    return v;
  endfunction

  // Advance the window for one accepted pixel and queue the result it makes
  function automatic void predict_pixel(input logic [7:0] px, input logic fs);
    int unsigned mw, mh, width, dv, col;
    logic [7:0] colv [MAX_MASK];
    logic row_last;
    longint acc, q;
    logic signed [COEF_BITS-1:0] k;
    conv_result_t res;
    mw = clip_dim(shape_q[2:0]);
    mh = clip_dim(shape_q[5:3]);
    width = width_q;
    dv = (div_q == 0) ? 1 : div_q;
    if (width == 0) width = 1;
    if (width > MAX_WIDTH) width = MAX_WIDTH;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    col = col_cnt % MAX_WIDTH;
    row_last = (col_cnt + 1 >= width);
    for (int r = 0; r < LINES; r++) colv[r] = line_mem[r][col];
    colv[MAX_MASK-1] = px;
    for (int r = 0; r < LINES; r++) line_mem[r][col] = colv[r+1];
    for (int r = 0; r < MAX_MASK; r++) begin
      for (int c = 0; c < MAX_MASK - 1; c++) win_q[r][c] = win_q[r][c+1];
      win_q[r][MAX_MASK-1] = colv[r];
    end
    if (col_cnt + 1 >= mw && row_cnt + 1 >= mh) begin
      acc = 0;
      for (int my = 0; my < mh; my++)
        for (int mx = 0; mx < mw; mx++) begin
          k = kern_q[my][mx*COEF_BITS +: COEF_BITS];
          acc += longint'(k) * longint'(win_q[MAX_MASK-mh+my][MAX_MASK-mw+mx]);
        end
      q = acc / longint'(dv);
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      res.value = q[7:0];
      res.col = COL_W'(col_cnt - (mw - 1));
      res.row = ROW_W'(row_cnt - (mh - 1));
      res.row_end = row_last;
      pending_q.push_back(res);
    end
    if (row_last) begin
      col_cnt = 0;
      if (row_cnt < MAX_HEIGHT - 1) row_cnt++;
    end else begin
      col_cnt++;
    end
  endfunction

  // Stall the output at random and check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result data=%h last=%b",
                                   m_axis_tdata_o, m_axis_tlast_o);
      end else begin
        conv_result_t exp_r;
        exp_r = pending_q.pop_front();
        if (m_axis_tdata_o[7:0] !== exp_r.value || m_axis_tdata_o[18:8] !== exp_r.col ||
            m_axis_tdata_o[30:19] !== exp_r.row || m_axis_tlast_o !== exp_r.row_end) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp val=%0d col=%0d row=%0d end=%b, ",
                      "got val=%0d col=%0d row=%0d end=%b"},
                     exp_r.value, exp_r.col, exp_r.row, exp_r.row_end,
                     m_axis_tdata_o[7:0], m_axis_tdata_o[18:8], m_axis_tdata_o[30:19],
                     m_axis_tlast_o);
        end
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // Write one register and mirror it in the predictor
  task automatic write_reg(input logic [2:0] idx, input logic [KROW_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx < KROWS) kern_q[idx] = val;
    else if (idx == REG_DIVISOR) div_q = val[11:0];
    else if (idx == REG_LINE_WIDTH) width_q = val[11:0];
    else if (idx == REG_MASK_SHAPE) shape_q = val[11:0];
  endtask

  // Send one pixel request; valid stays high for a back-to-back follower
  task automatic send_pixel(input logic [7:0] px, input logic fs);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= px;
    s_axis_tuser_i <= fs;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_pixel(px, fs);
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [KROW_W-1:0] rand_krow();
    logic [KROW_W-1:0] v;
    for (int c = 0; c < 5; c++)
      case ($urandom_range(3))
        0: v[c*COEF_BITS +: COEF_BITS] = 12'h800;
        1: v[c*COEF_BITS +: COEF_BITS] = 12'h7FF;
        2: v[c*COEF_BITS +: COEF_BITS] = 12'($signed($urandom_range(16)) - 4);
        default: v[c*COEF_BITS +: COEF_BITS] = 12'($urandom);
      endcase
    return v;
  endfunction

  // Directed: coefficient extremes, saturation both ways, 3x3 and 5x5 masks
  task automatic test_directed();
    write_reg(REG_KROW0, {12'h001, 12'h7FF, 12'h800, 12'h7FF, 12'h800});
    write_reg(REG_KROW0 + 3'd1, {5{12'h7FF}});
    write_reg(REG_KROW0 + 3'd2, {5{12'hFFF}});
    write_reg(REG_KROW0 + 3'd3, {5{12'h800}});
    write_reg(REG_KROW0 + 3'd4, {5{12'h001}});
    write_reg(REG_DIVISOR, 60'd1);
    write_reg(REG_LINE_WIDTH, 60'd5);
    write_reg(REG_MASK_SHAPE, 60'(3 | (3 << 3)));
    for (int i = 0; i < 20; i++)
      send_pixel((i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : 8'($urandom), i == 0);
    drain();
    write_reg(REG_MASK_SHAPE, 60'(12'hFFF));
    write_reg(REG_DIVISOR, 60'd4095);
    for (int i = 0; i < 25; i++) send_pixel((i % 2) ? 8'hFF : 8'h00, i == 0);
    drain();
  endtask

  // Widest line with a 1x1 mask: results come at once along the first row
  task automatic test_wide_line();
    write_reg(REG_LINE_WIDTH, 60'd2048);
    write_reg(REG_MASK_SHAPE, 60'd0);
    write_reg(REG_DIVISOR, 60'd1);
    for (int i = 0; i < 12; i++) send_pixel(8'($urandom), i == 0);
    drain();
  endtask

  // Random frames under one idle/stall setting; each frame sets width, divisor and mask shape anew
  task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                    input int n_items);
    int sent, fw, rows, n;
    logic fs;
    src_idle_pct = idle_pct;
    rcv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      fw = ($urandom_range(9) == 0) ? 5 : $urandom_range(5, 12);
      write_reg(REG_LINE_WIDTH, 60'(fw));
      for (int r = 0; r < KROWS; r++)
        if ($urandom_range(2) != 0) write_reg(REG_KROW0 + 3'(r), rand_krow());
      case ($urandom_range(5))
        0: write_reg(REG_DIVISOR, 60'd1);
        1: write_reg(REG_DIVISOR, 60'd4095);
        default: write_reg(REG_DIVISOR, 60'($urandom_range(1, 64)));
      endcase
      case ($urandom_range(7))
        0: write_reg(REG_MASK_SHAPE, 60'd0);
        1: write_reg(REG_MASK_SHAPE, 60'd4095);
        default: write_reg(REG_MASK_SHAPE, 60'($urandom_range(4095)));
      endcase
      rows = $urandom_range(1, 8);
      n = fw * rows;
      for (int i = 0; i < n; i++) begin
        // mostly clean frames; now and then a missing or stray frame start
        if (i == 0) fs = ($urandom_range(9) != 0);
        else fs = ($urandom_range(49) == 0);
        send_pixel(8'($urandom), fs);
      end
      sent += n;
      drain();
    end
  endtask

  initial begin
    for (int r = 0; r < KROWS; r++) kern_q[r] = '0;
    div_q = 12'd1;
    width_q = 12'd2048;
    shape_q = 12'd603;
    for (int r = 0; r < LINES; r++)
      for (int c = 0; c < MAX_WIDTH; c++) line_mem[r][c] = '0;
    for (int r = 0; r < MAX_MASK; r++)
      for (int c = 0; c < MAX_MASK; c++) win_q[r][c] = '0;
    col_cnt = 0;
    row_cnt = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_wide_line();
    test_random_frames(0, 0, 330);
    test_random_frames(82, 0, 330);
    test_random_frames(0, 82, 330);
    test_random_frames(9, 9, 330);

    if (errors == 0) begin
      $display("[image_convolution_2d] OK");
    end else begin
      $display("[image_convolution_2d] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
